// ----- rtl/gpio_ports_with_edge_interrupts_assert.svh -----
// Assertion macros for the GPIO port bank checker.
`ifndef GPIO_PORTS_WITH_EDGE_INTERRUPTS_ASSERT_SVH
`define GPIO_PORTS_WITH_EDGE_INTERRUPTS_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define GPIOEI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gpio port bank assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define GPIOEI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gpio port bank assertion failed");

`endif

// ----- rtl/gpioei_pkg.sv -----
// Types, codes and constants shared by the GPIO port bank files.
`timescale 1ns / 1ps

package gpioei_pkg;

  localparam int NUM_PORTS_DEF     = 9;
  localparam int NUM_IRQ_PORTS_DEF = 2;
  localparam logic [3:0] PORT_J_INDEX = 4'd8;

  typedef enum logic [2:0] {
    FUNC_READ  = 3'd0,
    FUNC_WRITE = 3'd1,
    FUNC_DRIVE = 3'd2,
    FUNC_CLEAR = 3'd3,
    FUNC_CHECK = 3'd4
  } func_t;

  localparam logic [3:0] REG_IN   = 4'd0;
  localparam logic [3:0] REG_OUT  = 4'd1;
  localparam logic [3:0] REG_DIR  = 4'd2;
  localparam logic [3:0] REG_FLAG = 4'd3;
  localparam logic [3:0] REG_EDGE = 4'd4;
  localparam logic [3:0] REG_EN   = 4'd5;
  localparam logic [3:0] REG_SEL  = 4'd6;
  localparam logic [3:0] REG_SEL2 = 4'd7;
  localparam logic [3:0] REG_REN  = 4'd8;

  // configuration register index
  localparam logic CFG_PULL_MODE = 1'b0;

  // one memory word per port
  typedef struct packed {
    logic [7:0] pin_in;
    logic [7:0] pin_out;
    logic [7:0] pin_dir;
    logic [7:0] func_sel;
    logic [7:0] func_sel2;
    logic [7:0] pull_enable;
    logic [7:0] in_marks;
    logic [7:0] out_marks;
  } port_word_t;

endpackage

// ----- rtl/gpio_ports_with_edge_interrupts.sv -----
// Top level of the GPIO port bank with edge interrupt flags.
`timescale 1ns / 1ps

// Bank of NUM_PORTS 8-bit GPIO ports; the first NUM_IRQ_PORTS carry interrupt
// flag, edge select and enable registers. Each request is a bus read or write,
// a pin drive, a clear of all change marks or an interrupt check, and gives one
// result. The port's word is read from a synchronous memory when the request is
// taken, then modified and written back as the result is registered. The next
// request is taken the cycle after write back, so a new request is not taken
// before the last one is written back. A result waiting on out_stall holds the
// request in progress, so one more request is taken and then the input stalls
// until the result drains. Per-port valid bits make the memory read as zero
// after reset, with no clearing pass.
module gpio_ports_with_edge_interrupts #(
  parameter int NUM_PORTS     = gpioei_pkg::NUM_PORTS_DEF,
  parameter int NUM_IRQ_PORTS = gpioei_pkg::NUM_IRQ_PORTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_func,
  input  logic [3:0]  in_port,
  input  logic [3:0]  in_reg_select,
  input  logic [7:0]  in_wdata,
  input  logic [7:0]  in_pin_mask,
  input  logic [7:0]  in_pull_mask,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_rdata,
  output logic        out_access_error,
  output logic        out_irq_port1,
  output logic        out_irq_port2,
  output logic [7:0]  out_port_out_value,
  output logic [7:0]  out_port_out_changed,
  output logic [7:0]  out_port_in_changed,
  output logic [7:0]  out_port_dir_value,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int IDXW = $clog2(NUM_PORTS);

  // configuration
  logic pull_mode_r;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pull_mode_r <= 1'b1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr[2] == gpioei_pkg::CFG_PULL_MODE) begin
      pull_mode_r <= cfg_pwdata[0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == gpioei_pkg::CFG_PULL_MODE) begin
      cfg_prdata = {31'd0, pull_mode_r};
    end
  end

  // request stage
  logic              s1_valid_r;
  logic [2:0]        s1_func_r;
  logic [3:0]        s1_port_r;
  logic [3:0]        s1_reg_r;
  logic [7:0]        s1_wdata_r;
  logic [7:0]        s1_pm_r;
  logic [7:0]        s1_pu_r;
  logic              s1_ok_r;
  logic [IDXW-1:0]   s1_addr_r;

  logic              in_acc;
  logic              s1_done;
  logic              in_ok;
  logic [IDXW-1:0]   rd_addr;

  assign in_stall = s1_valid_r;
  assign in_acc   = in_valid && !s1_valid_r;
  assign s1_done  = s1_valid_r && (!out_valid || !out_stall);
  assign in_ok    = 32'(in_port) < NUM_PORTS;
  assign rd_addr  = in_ok ? in_port[IDXW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_done) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r  <= in_func;
      s1_port_r  <= in_port;
      s1_reg_r   <= in_reg_select;
      s1_wdata_r <= in_wdata;
      s1_pm_r    <= in_pin_mask;
      s1_pu_r    <= in_pull_mask;
      s1_ok_r    <= in_ok;
      s1_addr_r  <= rd_addr;
    end
  end

  // port memory
  gpioei_pkg::port_word_t port_mem [NUM_PORTS];
  gpioei_pkg::port_word_t rd_word_r;
  gpioei_pkg::port_word_t nw;
  logic [NUM_PORTS-1:0]   entry_valid_r;
  logic [NUM_PORTS-1:0]   marks_valid_r;
  logic                   mem_we;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_word_r <= port_mem[rd_addr];
    end
    if (mem_we) begin
      port_mem[s1_addr_r] <= nw;
    end
  end

  // interrupt registers
  logic [7:0] irq_flags_r   [NUM_IRQ_PORTS];
  logic [7:0] edge_select_r [NUM_IRQ_PORTS];
  logic [7:0] irq_enable_r  [NUM_IRQ_PORTS];

  logic [7:0] flg, edg, ena;
  logic [7:0] flg_new, edg_new, ena_new;
  logic       is_irq_port;
  logic       reg_exists;
  logic       err;
  logic [7:0] rdata;
  logic [1:0] irq_v;
  logic       raise;
  logic       clear_all;
  gpioei_pkg::port_word_t cur;
  logic [7:0] ndir, nv, ifg;

  always_comb begin
    cur = entry_valid_r[s1_addr_r] ? rd_word_r : '0;
    if (!marks_valid_r[s1_addr_r]) begin
      cur.in_marks  = '0;
      cur.out_marks = '0;
    end

    flg = '0;
    edg = '0;
    ena = '0;
    is_irq_port = 1'b0;
    for (int i = 0; i < NUM_IRQ_PORTS; i++) begin
      if (s1_port_r == 4'(i)) begin
        flg = irq_flags_r[i];
        edg = edge_select_r[i];
        ena = irq_enable_r[i];
        is_irq_port = 1'b1;
      end
    end

    unique case (s1_reg_r)
      gpioei_pkg::REG_IN, gpioei_pkg::REG_OUT,
      gpioei_pkg::REG_DIR, gpioei_pkg::REG_REN:   reg_exists = s1_ok_r;
      gpioei_pkg::REG_FLAG, gpioei_pkg::REG_EDGE,
      gpioei_pkg::REG_EN:                         reg_exists = s1_ok_r && is_irq_port;
      gpioei_pkg::REG_SEL, gpioei_pkg::REG_SEL2:
        reg_exists = s1_ok_r && (s1_port_r != gpioei_pkg::PORT_J_INDEX);
      default:                                    reg_exists = 1'b0;
    endcase

    nw        = cur;
    flg_new   = flg;
    edg_new   = edg;
    ena_new   = ena;
    err       = 1'b0;
    rdata     = '0;
    raise     = 1'b0;
    irq_v     = '0;
    clear_all = 1'b0;
    ndir      = ~cur.pin_dir;
    nv        = '0;
    ifg       = '0;

    unique case (s1_func_r)
      gpioei_pkg::FUNC_READ: begin
        err = !reg_exists;
        if (reg_exists) begin
          unique case (s1_reg_r)
            gpioei_pkg::REG_IN:   rdata = cur.pin_in;
            gpioei_pkg::REG_OUT:  rdata = cur.pin_out;
            gpioei_pkg::REG_DIR:  rdata = cur.pin_dir;
            gpioei_pkg::REG_FLAG: rdata = flg;
            gpioei_pkg::REG_EDGE: rdata = edg;
            gpioei_pkg::REG_EN:   rdata = ena;
            gpioei_pkg::REG_SEL:  rdata = cur.func_sel;
            gpioei_pkg::REG_SEL2: rdata = cur.func_sel2;
            default:              rdata = cur.pull_enable;
          endcase
        end
      end
      gpioei_pkg::FUNC_WRITE: begin
        if (!reg_exists || s1_reg_r == gpioei_pkg::REG_IN) begin
          err = 1'b1;
        end else begin
          unique case (s1_reg_r)
            gpioei_pkg::REG_OUT: begin
              nw.pin_out   = s1_wdata_r & ~cur.func_sel;
              nw.out_marks = cur.pin_out ^ nw.pin_out;
            end
            gpioei_pkg::REG_FLAG: begin
              raise   = ((s1_wdata_r & ~flg) != '0) && ((ena & s1_wdata_r) != '0);
              flg_new = s1_wdata_r;
            end
            gpioei_pkg::REG_EDGE: edg_new      = s1_wdata_r;
            gpioei_pkg::REG_EN:   ena_new      = s1_wdata_r;
            gpioei_pkg::REG_DIR:  nw.pin_dir   = s1_wdata_r;
            gpioei_pkg::REG_SEL:  nw.func_sel  = s1_wdata_r;
            gpioei_pkg::REG_SEL2: nw.func_sel2 = s1_wdata_r;
            default:              nw.pull_enable = s1_wdata_r;
          endcase
        end
      end
      gpioei_pkg::FUNC_DRIVE: begin
        if (!s1_ok_r) begin
          err = 1'b1;
        end else begin
          if (pull_mode_r && s1_pu_r != '0) begin
            nv = (cur.pin_in & ~s1_pm_r & ~s1_pu_r) |
                 (s1_wdata_r & s1_pm_r & ~s1_pu_r & ndir) |
                 (s1_pu_r & cur.pull_enable & cur.pin_out & ndir);
          end else begin
            nv = (cur.pin_in & ~s1_pm_r) | (s1_wdata_r & s1_pm_r & ndir);
          end
          nw.pin_in   = nv;
          nw.in_marks = cur.pin_in ^ nv;
          if (is_irq_port) begin
            // falling edges where edge select is set, rising where clear
            ifg = (~s1_wdata_r & cur.pin_in & s1_pm_r & edg) |
                  (s1_wdata_r & ~cur.pin_in & s1_pm_r & ~edg);
            flg_new = flg | ifg;
            raise   = (ena & ifg) != '0;
          end
        end
      end
      gpioei_pkg::FUNC_CLEAR: begin
        clear_all    = 1'b1;
        nw.in_marks  = '0;
        nw.out_marks = '0;
      end
      gpioei_pkg::FUNC_CHECK: begin
        for (int i = 0; i < NUM_IRQ_PORTS; i++) begin
          irq_v[1'(i)] = (irq_flags_r[i] & irq_enable_r[i]) != '0;
        end
      end
      default: begin
      end
    endcase

    if (raise) begin
      irq_v[s1_port_r[0]] = 1'b1;
    end

    mem_we = s1_done && s1_ok_r &&
             (s1_func_r == gpioei_pkg::FUNC_WRITE || s1_func_r == gpioei_pkg::FUNC_DRIVE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= '0;
      marks_valid_r <= '0;
    end else if (s1_done) begin
      if (clear_all) begin
        marks_valid_r <= '0;
      end else if (mem_we) begin
        entry_valid_r[s1_addr_r] <= 1'b1;
        marks_valid_r[s1_addr_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_IRQ_PORTS; i++) begin
        irq_flags_r[i]   <= '0;
        edge_select_r[i] <= '0;
        irq_enable_r[i]  <= '0;
      end
    end else if (s1_done) begin
      for (int i = 0; i < NUM_IRQ_PORTS; i++) begin
        if (s1_port_r == 4'(i)) begin
          irq_flags_r[i]   <= flg_new;
          edge_select_r[i] <= edg_new;
          irq_enable_r[i]  <= ena_new;
        end
      end
    end
  end

  // result register
  logic out_valid_r;

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done) begin
      out_rdata            <= rdata;
      out_access_error     <= err;
      out_irq_port1        <= irq_v[0];
      out_irq_port2        <= irq_v[1];
      out_port_out_value   <= s1_ok_r ? nw.pin_out   : '0;
      out_port_out_changed <= s1_ok_r ? nw.out_marks : '0;
      out_port_in_changed  <= s1_ok_r ? nw.in_marks  : '0;
      out_port_dir_value   <= s1_ok_r ? nw.pin_dir   : '0;
    end
  end

endmodule

// ----- rtl/gpioei_checker.sv -----
// Port-level checker for the GPIO port bank, bound to the top level.
`timescale 1ns / 1ps
`include "gpio_ports_with_edge_interrupts_assert.svh"

module gpioei_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_rdata,
  input logic       out_access_error
);

  // a stalled result stays up
  `GPIOEI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // an accepted request keeps the input side busy the next cycle
  `GPIOEI_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // a new result only comes from a request in progress
  `GPIOEI_ASSERT_NOW(a_result_from_request, $rose(out_valid), $past(in_stall))

  // failed accesses return no data
  `GPIOEI_ASSERT_NOW(a_error_no_data, out_valid && out_access_error, out_rdata == 8'd0)

endmodule

bind gpio_ports_with_edge_interrupts gpioei_checker u_gpioei_checker (.*);
